// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the BM25 max-score RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define BMTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true out of reset.
`define BMTS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/core/bmts_pkg.sv =====
// Types, widths and constants of the BM25 max-score block.
// No dependencies.
package bmts_pkg;

  localparam int DF_W    = 24;
  localparam int TF_W    = 16;
  localparam int LEN_W   = 24;
  localparam int Q_W     = 32;
  localparam int K1_W    = 19;
  localparam int B_W     = 17;
  localparam int CIDX_W  = 4;
  localparam int CDAT_W  = 32;

  // Shared divider
  localparam int REM_W   = 37;
  localparam int DVD_W   = 42;
  localparam int ITER_W  = 6;
  localparam int XNORM_W = 42;

  localparam logic [ITER_W-1:0] IDF_ITERS = 6'd42;
  localparam logic [ITER_W-1:0] LR_ITERS  = 6'd32;
  localparam logic [ITER_W-1:0] T_ITERS   = 6'd20;

  localparam logic [Q_W-1:0]  LN2_Q32       = 32'd2977044472;
  localparam logic [B_W-1:0]  ONE_Q16       = 17'd65536;
  localparam logic [Q_W-1:0]  AVGDL_RESET   = 32'd65536;
  localparam logic [K1_W-1:0] K1_RESET      = 19'd78643;
  localparam logic [B_W-1:0]  B_RESET       = 17'd13107;
  localparam logic [4:0]      LOG_INT_TOP   = 5'd25;
  localparam logic [3:0]      LOG_FRAC_TOP  = 4'd15;

  typedef enum logic [CIDX_W-1:0] {
    REG_DOC_COUNT  = 4'd0,
    REG_AVG_DOCLEN = 4'd1,
    REG_TF_SAT     = 4'd2,
    REG_LEN_WEIGHT = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DF_W-1:0]  doc_count;
    logic [Q_W-1:0]   avg_doc_length;
    logic [K1_W-1:0]  tf_saturation;
    logic [B_W-1:0]   length_weight;
  } cfg_t;

  typedef struct packed {
    logic [DF_W-1:0]  term_df;
    logic [TF_W-1:0]  term_freq;
    logic [LEN_W-1:0] doc_length;
    logic             last_in_term;
    logic             first;
  } qent_t;

  typedef struct packed {
    logic              start;
    logic [REM_W-1:0]  rem0;
    logic [REM_W-1:0]  divisor;
    logic [DVD_W-1:0]  dividend;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_IDF_DIV,
    B_NORM,
    B_SQ_MUL,
    B_SQ_CHK,
    B_IDF_MUL,
    B_IDF_WR,
    B_LR,
    B_LR_DIV,
    B_BL_MUL,
    B_NORM_WR,
    B_KN_MUL,
    B_DEN_WR,
    B_NUM_MUL,
    B_T_DIV_ST,
    B_T_DIV,
    B_SC_MUL,
    B_SC_WR,
    B_EMIT
  } back_state_e;

endpackage

// ===== rtl/core/bmts_if.sv =====
// Channel interfaces of the BM25 max-score block: postings, entries, config.
// Depends on bmts_pkg.
interface bmts_post_if import bmts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DF_W-1:0]  term_df;
  logic [TF_W-1:0]  term_freq;
  logic [LEN_W-1:0] doc_length;
  logic             last_in_term;
  modport source (output valid, term_df, term_freq, doc_length, last_in_term, input ready);
  modport sink   (input valid, term_df, term_freq, doc_length, last_in_term, output ready);
endinterface

interface bmts_entry_if import bmts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [DF_W-1:0] entry_df;
  logic [Q_W-1:0]  peak_score;
  logic [Q_W-1:0]  list_offset;
  logic [Q_W-1:0]  posting_words;
  modport source (output valid, entry_df, peak_score, list_offset, posting_words,
                  input ready);
  modport sink   (input valid, entry_df, peak_score, list_offset, posting_words,
                  output ready);
endinterface

interface bmts_cfg_if import bmts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bmts_fifo.sv =====
// Two-entry queue between the front and the back of the BM25 block.
// Depends on bmts_pkg.
module bmts_fifo import bmts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output qent_t rdata_o
);

  qent_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

endmodule

// ===== rtl/core/bmts_front.sv =====
// Front of the BM25 block: config registers, posting intake, group-start marking.
// Depends on bmts_pkg and bmts_if.
module bmts_front import bmts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmts_post_if.sink   post_i,
  bmts_cfg_if.sink    cfg_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output qent_t       q_data_o,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic in_group_q;

  assign cfg_i.ready  = 1'b1;
  assign post_i.ready = !q_full_i;
  assign q_push_o     = post_i.valid && !q_full_i;

  always_comb begin
    q_data_o.term_df      = post_i.term_df;
    q_data_o.term_freq    = post_i.term_freq;
    q_data_o.doc_length   = post_i.doc_length;
    q_data_o.last_in_term = post_i.last_in_term;
    q_data_o.first        = !in_group_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_group_q           <= 1'b0;
      cfg_q.doc_count      <= '0;
      cfg_q.avg_doc_length <= AVGDL_RESET;
      cfg_q.tf_saturation  <= K1_RESET;
      cfg_q.length_weight  <= B_RESET;
    end else begin
      if (q_push_o) in_group_q <= !post_i.last_in_term;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_DOC_COUNT:  cfg_q.doc_count      <= cfg_i.data[DF_W-1:0];
          REG_AVG_DOCLEN: cfg_q.avg_doc_length <= cfg_i.data[Q_W-1:0];
          REG_TF_SAT:     cfg_q.tf_saturation  <= cfg_i.data[K1_W-1:0];
          REG_LEN_WEIGHT: cfg_q.length_weight  <= cfg_i.data[B_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/bmts_div.sv =====
// Shared restoring divider of the BM25 block, one quotient bit per cycle.
// Depends on bmts_pkg.
module bmts_div import bmts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [REM_W-1:0]  rem_q, dsr_q;
  logic [DVD_W-1:0]  dvd_q, quo_q;
  logic [ITER_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [REM_W:0]    trial, diff;
  logic              ge;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem0;
      dsr_q <= req_i.divisor;
      dvd_q <= req_i.dividend;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ===== rtl/core/bmts_back.sv =====
// Back of the BM25 block: idf, score, running maximum and entry output.
// Depends on bmts_pkg, bmts_if, bmts_div and assert_macros.svh.
`include "assert_macros.svh"
module bmts_back import bmts_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         q_valid_i,
  input  qent_t        q_data_i,
  output logic         q_pop_o,
  bmts_entry_if.source entry_o
);

  back_state_e state_q, state_d;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  qent_t              item_q;
  logic [Q_W-1:0]     idf_q, rmax_q, cnt_q, woff_q;
  logic [XNORM_W-1:0] xs_q;
  logic [4:0]         shcnt_q, lint_q;
  logic [15:0]        lfrac_q;
  logic [3:0]         sqi_q;
  logic [30:0]        m_q;
  logic [Q_W-1:0]     lr_q, norm_q;
  logic [REM_W-1:0]   den_q;
  logic [K1_W:0]      t_q;
  logic [63:0]        prod_q, mul_p;
  logic [Q_W-1:0]     mul_a, mul_b;

  logic               out_valid_q;
  logic [DF_W-1:0]    out_df_q;
  logic [Q_W-1:0]     out_max_q, out_off_q, out_words_q;

  logic [B_W-1:0]     b_eff;
  logic [K1_W:0]      k1p1;
  logic [DF_W:0]      rest_sum;
  logic [DF_W-1:0]    rest;
  logic [25:0]        idf_num;
  logic [31:0]        mm;
  logic [32:0]        norm_sum;
  logic [47:0]        score_w;
  logic [Q_W-1:0]     score, new_max, new_cnt;
  logic               emit_ok;
  logic               div_wait;

  bmts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign b_eff    = (cfg_i.length_weight > ONE_Q16) ? ONE_Q16 : cfg_i.length_weight;
  assign k1p1     = {1'b0, cfg_i.tf_saturation} + (K1_W+1)'(ONE_Q16);
  assign rest     = (cfg_i.doc_count > item_q.term_df) ?
                    (cfg_i.doc_count - item_q.term_df) : '0;
  assign rest_sum = {1'b0, rest} + {1'b0, item_q.term_df};
  assign idf_num  = {rest_sum, 1'b0} + 26'd2;
  assign mm       = prod_q[61:30];
  assign norm_sum = 33'(ONE_Q16 - b_eff) + prod_q[48:16];
  assign score_w  = prod_q[63:16];
  assign score    = (score_w[47:32] != '0) ? '1 : score_w[31:0];
  assign new_max  = (score > rmax_q) ? score : rmax_q;
  assign new_cnt  = cnt_q + 1'b1;
  assign emit_ok  = !out_valid_q || entry_o.ready;
  assign mul_p    = mul_a * mul_b;
  assign div_wait = (state_q == B_IDF_DIV) || (state_q == B_LR_DIV) || (state_q == B_T_DIV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= B_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d          = state_q;
    q_pop_o          = 1'b0;
    div_req          = '0;
    mul_a            = '0;
    mul_b            = '0;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = q_data_i.first ? B_IDF_DIV : B_LR;
        end
      end
      B_IDF_DIV: begin
        // Start the idf quotient on the first cycle after the pop.
        if (!div_rsp.busy && !div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.rem0     = '0;
          div_req.divisor  = REM_W'({item_q.term_df, 1'b1});
          div_req.dividend = {idf_num, 16'd0};
          div_req.iters    = IDF_ITERS;
        end
        if (div_rsp.done) state_d = B_NORM;
      end
      B_NORM:   if (xs_q[XNORM_W-1]) state_d = B_SQ_MUL;
      B_SQ_MUL: begin
        mul_a   = {1'b0, m_q};
        mul_b   = {1'b0, m_q};
        state_d = B_SQ_CHK;
      end
      B_SQ_CHK: state_d = (sqi_q == 4'd0) ? B_IDF_MUL : B_SQ_MUL;
      B_IDF_MUL: begin
        mul_a   = Q_W'({lint_q, lfrac_q});
        mul_b   = LN2_Q32;
        state_d = B_IDF_WR;
      end
      B_IDF_WR: state_d = B_LR;
      B_LR: begin
        if (cfg_i.avg_doc_length == '0 ||
            Q_W'(item_q.doc_length) >= cfg_i.avg_doc_length) begin
          state_d = B_BL_MUL;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem0     = REM_W'(item_q.doc_length);
          div_req.divisor  = REM_W'(cfg_i.avg_doc_length);
          div_req.dividend = '0;
          div_req.iters    = LR_ITERS;
          state_d          = B_LR_DIV;
        end
      end
      B_LR_DIV: if (div_rsp.done) state_d = B_BL_MUL;
      B_BL_MUL: begin
        mul_a   = Q_W'(b_eff);
        mul_b   = lr_q;
        state_d = B_NORM_WR;
      end
      B_NORM_WR: state_d = B_KN_MUL;
      B_KN_MUL: begin
        mul_a   = Q_W'(cfg_i.tf_saturation);
        mul_b   = norm_q;
        state_d = B_DEN_WR;
      end
      B_DEN_WR: state_d = B_NUM_MUL;
      B_NUM_MUL: begin
        mul_a   = Q_W'(item_q.term_freq);
        mul_b   = Q_W'(k1p1);
        state_d = B_T_DIV_ST;
      end
      B_T_DIV_ST: begin
        if (den_q == '0) begin
          state_d = B_SC_MUL;
        end else begin
          // The quotient never exceeds k1 + 1.0, so 20 bits cover the full k1 range
          div_req.start    = 1'b1;
          div_req.rem0     = REM_W'(prod_q[35:4]);
          div_req.divisor  = den_q;
          div_req.dividend = {prod_q[3:0], 16'd0, 22'd0};
          div_req.iters    = T_ITERS;
          state_d          = B_T_DIV;
        end
      end
      B_T_DIV: if (div_rsp.done) state_d = B_SC_MUL;
      B_SC_MUL: begin
        mul_a   = idf_q;
        mul_b   = Q_W'(t_q);
        state_d = B_SC_WR;
      end
      B_SC_WR:  state_d = item_q.last_in_term ? B_EMIT : B_IDLE;
      B_EMIT:   if (emit_ok) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      B_IDLE: if (q_valid_i) item_q <= q_data_i;
      B_IDF_DIV: begin
        if (div_rsp.done) begin
          xs_q    <= div_rsp.quot;
          shcnt_q <= '0;
        end
      end
      B_NORM: begin
        if (xs_q[XNORM_W-1]) begin
          m_q     <= xs_q[XNORM_W-1:11];
          lint_q  <= LOG_INT_TOP - shcnt_q;
          lfrac_q <= '0;
          sqi_q   <= LOG_FRAC_TOP;
        end else begin
          xs_q    <= {xs_q[XNORM_W-2:0], 1'b0};
          shcnt_q <= shcnt_q + 1'b1;
        end
      end
      B_SQ_CHK: begin
        if (mm[31]) begin
          m_q            <= mm[31:1];
          lfrac_q[sqi_q] <= 1'b1;
        end else begin
          m_q <= mm[30:0];
        end
        sqi_q <= sqi_q - 1'b1;
      end
      B_IDF_WR:  idf_q <= Q_W'(prod_q[52:32]);
      B_LR:      lr_q  <= '1;
      B_LR_DIV:  if (div_rsp.done) lr_q <= div_rsp.quot[Q_W-1:0];
      B_NORM_WR: norm_q <= norm_sum[Q_W-1:0];
      B_DEN_WR:  den_q <= {5'd0, item_q.term_freq, 16'd0} + REM_W'(prod_q[51:16]);
      B_T_DIV_ST: t_q <= '0;
      B_T_DIV:   if (div_rsp.done) t_q <= div_rsp.quot[K1_W:0];
      default: ;
    endcase
  end

  // Group state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmax_q      <= '0;
      cnt_q       <= '0;
      woff_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == B_IDLE && q_valid_i && q_data_i.first) begin
        rmax_q <= '0;
        cnt_q  <= '0;
      end
      if (state_q == B_SC_WR) begin
        rmax_q <= new_max;
        cnt_q  <= new_cnt;
      end
      if (state_q == B_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
        woff_q      <= woff_q + {cnt_q[Q_W-3:0], 2'b00};
      end else if (out_valid_q && entry_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_EMIT && emit_ok) begin
      out_df_q    <= item_q.term_df;
      out_max_q   <= rmax_q;
      out_off_q   <= woff_q;
      out_words_q <= {cnt_q[Q_W-3:0], 2'b00};
    end
  end

  assign entry_o.valid         = out_valid_q;
  assign entry_o.entry_df      = out_df_q;
  assign entry_o.peak_score    = out_max_q;
  assign entry_o.list_offset   = out_off_q;
  assign entry_o.posting_words = out_words_q;

  `BMTS_NEVER(a_div_start_busy, div_req.start && div_rsp.busy, "divider restarted while busy")
  `BMTS_ASSERT(a_div_done_wait, div_rsp.done |-> div_wait, "divider result with no waiting step")
  `BMTS_ASSERT(a_pop_nonempty, q_pop_o |-> q_valid_i, "pop from empty queue")

endmodule

// ===== rtl/core/bm25_term_max_score_core.sv =====
// BM25 term max-score core: front intake, two-entry queue, iterative back end.
// Each posting makes one pass through the back end: a length-ratio divide, a score divide
// and multiplier steps with registered products; the length-ratio divide is skipped when
// the ratio saturates. A term's first posting adds the idf divide, the normalising shifts
// and 16 squaring steps. The entry is output after the term's closing posting.
// The back end takes the next posting from the queue only after its pass is done.
// Asynchronous active-low reset clears control state and loads register defaults.
module bm25_term_max_score_core import bmts_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bmts_post_if.sink    post_i,
  bmts_cfg_if.sink     cfg_i,
  bmts_entry_if.source entry_o
);

  logic  q_push, q_full, q_pop, q_valid;
  qent_t q_wdata, q_rdata;
  cfg_t  cfg;

  bmts_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .post_i   (post_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .cfg_o    (cfg)
  );

  bmts_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  bmts_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .entry_o   (entry_o)
  );

endmodule
